// ===== rtl/core/sorted_max_priority_queue_defines.svh =====
// Assertion macros shared by the checker of the sorted max-priority queue.
// Each macro expands to one labeled concurrent assertion on a clock and reset.
`ifndef SORTED_MAX_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_MAX_PRIORITY_QUEUE_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define SMPQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("smpq: same-cycle property failed");

// The consequent holds in the cycle after the antecedent.
`define SMPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("smpq: next-cycle property failed");

`endif

// ===== rtl/core/smpq_pkg.sv =====
// Package for the sorted max-priority queue: sizes, operation codes and the
// structs passed between the cells. No dependencies.
`default_nettype none

package smpq_pkg;

	localparam int CAPACITY = 16;
	localparam int PRIO_W   = 32;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int ENTRY_W  = 5;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_REMOVE = 1'b1;

	// Operation broadcast to every cell in the same cycle.
	typedef struct packed {
		logic              ins;
		logic              rem;
		logic [PRIO_W-1:0] prio;
	} smpq_cmd_t;

	// What a cell shows its neighbors.
	typedef struct packed {
		logic              lt;
		logic              valid;
		logic [PRIO_W-1:0] value;
	} smpq_link_t;

endpackage

`default_nettype wire

// ===== rtl/core/sorted_max_priority_queue.sv =====
// Sorted max-priority queue: a row of cells kept in descending order.
// The result strobe rises in the cycle after start; one item per cycle.
// Each cell compares with the new priority in parallel; a shift is one place.
// busy is always low and the receiver cannot stall; results are never held.
// Reset clears all valid bits and the entry count; the queue starts empty.
// Depends on smpq_pkg and smpq_cell.
`default_nettype none

module sorted_max_priority_queue (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	output logic                         busy,
	input  wire                          func,
	input  wire  [smpq_pkg::PRIO_W-1:0]  priority_req,
	output logic                         done,
	output logic                         done_ok,
	output logic [smpq_pkg::PRIO_W-1:0]  top_value,
	output logic [smpq_pkg::ENTRY_W-1:0] entry_count,
	output logic                         is_empty
);
	import smpq_pkg::*;

	smpq_cmd_t  cmd;
	smpq_link_t link [CAPACITY];
	smpq_link_t prev_link [CAPACITY];
	smpq_link_t next_link [CAPACITY];

	logic             full;
	logic             empty;
	logic [CNT_W-1:0] count_q;
	logic             done_q;
	logic             ok_q;

	assign full  = link[CAPACITY-1].valid;
	assign empty = !link[0].valid;

	assign cmd.ins  = start && (func == FUNC_INSERT) && !full;
	assign cmd.rem  = start && (func == FUNC_REMOVE) && !empty;
	assign cmd.prio = priority_req;

	genvar i;
	generate
		for (i = 0; i < CAPACITY; i++) begin : g_cell
			if (i == 0) begin : g_head
				assign prev_link[i] = '0;
			end else begin : g_mid
				assign prev_link[i] = link[i-1];
			end
			if (i == CAPACITY - 1) begin : g_tail
				assign next_link[i] = '0;
			end else begin : g_body
				assign next_link[i] = link[i+1];
			end
			smpq_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.cmd    (cmd),
				.prev   (prev_link[i]),
				.next   (next_link[i]),
				.self   (link[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
			ok_q    <= 1'b0;
		end else begin
			done_q <= start;
			ok_q   <= cmd.ins || cmd.rem;
			if (cmd.ins) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.rem) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// The cells already hold the state after the step when the strobe is up.
	assign busy        = 1'b0;
	assign done        = done_q;
	assign done_ok     = ok_q;
	assign top_value   = link[0].valid ? link[0].value : '0;
	assign entry_count = ENTRY_W'({{ENTRY_W{1'b0}}, count_q});
	assign is_empty    = empty;

endmodule

`default_nettype wire

// ===== rtl/core/smpq_cell.sv =====
// One storage cell of the sorted queue: holds one entry and its valid bit.
// Depends on smpq_pkg for the command and link structs.
`default_nettype none

module smpq_cell (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire smpq_pkg::smpq_cmd_t  cmd,
	input  wire smpq_pkg::smpq_link_t prev,
	input  wire smpq_pkg::smpq_link_t next,
	output smpq_pkg::smpq_link_t      self
);
	import smpq_pkg::*;

	logic              valid_q;
	logic [PRIO_W-1:0] value_q;
	logic              lt;

	// An empty cell counts as smaller than anything, so the insert point is
	// the first cell that is empty or strictly smaller.
	assign lt = !valid_q || ($signed(value_q) < $signed(cmd.prio));

	assign self.lt    = lt;
	assign self.valid = valid_q;
	assign self.value = value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.ins) begin
			if (lt && prev.lt) begin
				valid_q <= prev.valid;
			end else if (lt) begin
				valid_q <= 1'b1;
			end
		end else if (cmd.rem) begin
			valid_q <= next.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (lt && prev.lt) begin
				value_q <= prev.value;
			end else if (lt) begin
				value_q <= cmd.prio;
			end
		end else if (cmd.rem) begin
			value_q <= next.value;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/smpq_checker.sv =====
// Port-level checker for the sorted max-priority queue, bound to the top level.
// Depends on smpq_pkg and the assertion macros header.
`default_nettype none
`include "sorted_max_priority_queue_defines.svh"

module smpq_checker (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          start,
	input wire                          busy,
	input wire                          done,
	input wire                          done_ok,
	input wire [smpq_pkg::PRIO_W-1:0]   top_value,
	input wire [smpq_pkg::ENTRY_W-1:0]  entry_count,
	input wire                          is_empty
);
	import smpq_pkg::*;

	// Every accepted item gets exactly one result in the following cycle.
	`SMPQ_ASSERT_NEXT(a_result_follows, clk, arst_n, start && !busy, done)
	`SMPQ_ASSERT_NEXT(a_no_spurious, clk, arst_n, !(start && !busy), !done)
	`SMPQ_ASSERT_NOW(a_ok_with_strobe, clk, arst_n, done_ok, done)
	`SMPQ_ASSERT_NOW(a_empty_count, clk, arst_n, done, is_empty == (entry_count == '0))
	`SMPQ_ASSERT_NOW(a_empty_top, clk, arst_n, done && is_empty, top_value == '0)

endmodule

bind sorted_max_priority_queue smpq_checker u_smpq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.done_ok     (done_ok),
	.top_value   (top_value),
	.entry_count (entry_count),
	.is_empty    (is_empty)
);

`default_nettype wire

// ===== verif/tb_sorted_max_priority_queue.sv =====
// Testbench for sorted_max_priority_queue: directed and random inserts and removes,
// each result checked against a sorted-list model of the queue kept in the bench.
// Depends on smpq_pkg and the RTL of the queue.
`timescale 1ns / 100ps

module tb_sorted_max_priority_queue;

	import smpq_pkg::*;

	typedef struct {
		logic               ok;
		logic [PRIO_W-1:0]  top;
		logic [ENTRY_W-1:0] count;
		logic               empty;
	} queue_status_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic func = FUNC_INSERT;
	logic [PRIO_W-1:0] priority_req = '0;
	logic busy;
	logic done;
	logic done_ok;
	logic [PRIO_W-1:0] top_value;
	logic [ENTRY_W-1:0] entry_count;
	logic is_empty;

	// Bench copy of the queue contents, greatest priority first.
	logic signed [PRIO_W-1:0] sorted_prio[CAPACITY];
	int sorted_len = 0;

	queue_status_t status_q[$];
	int error_count = 0;
	int idle_pct = 26;

	sorted_max_priority_queue u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.priority_req(priority_req),
		.done(done),
		.done_ok(done_ok),
		.top_value(top_value),
		.entry_count(entry_count),
		.is_empty(is_empty)
	);

	always #5 clk = ~clk;

	// Applies one accepted operation to the bench queue and records the expected status.
	task automatic apply_queue_op(input logic f, input logic signed [PRIO_W-1:0] p);
		queue_status_t st;
		int pos;
		st.ok = 1'b0;
		if (f == FUNC_INSERT) begin
			if (sorted_len < CAPACITY) begin
				pos = 0;
				while (pos < sorted_len && !(sorted_prio[pos] < p))
					pos++;
				for (int k = sorted_len; k > pos; k--)
					sorted_prio[k] = sorted_prio[k-1];
				sorted_prio[pos] = p;
				sorted_len++;
				st.ok = 1'b1;
			end
		end else if (sorted_len > 0) begin
			for (int k = 1; k < sorted_len; k++)
				sorted_prio[k-1] = sorted_prio[k];
			sorted_len--;
			st.ok = 1'b1;
		end
		st.empty = (sorted_len == 0);
		st.top = st.empty ? '0 : sorted_prio[0];
		st.count = sorted_len[ENTRY_W-1:0];
		status_q.push_back(st);
	endtask

	// Drives one item at a falling edge, possibly after idle cycles of noise,
	// and holds it until the block takes it.
	task automatic send_item(input logic f, input logic [PRIO_W-1:0] p);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start = 1'b0;
			func = 1'($urandom);
			priority_req = $urandom;
		end
		@(negedge clk);
		start = 1'b1;
		func = f;
		priority_req = p;
		do
			@(posedge clk);
		while (busy);
		apply_queue_op(f, p);
	endtask

	function automatic logic [PRIO_W-1:0] pick_prio();
		case ($urandom_range(11))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return '0;
			3: return '1;
			4, 5, 6: return $urandom_range(15) - 8;
			// Repeating the current head makes ties at the front of the queue.
			7: return (sorted_len > 0) ? sorted_prio[0] : $urandom;
			default: return $urandom;
		endcase
	endfunction

	task automatic test_empty_and_extremes();
		send_item(FUNC_REMOVE, 32'h7FFF_FFFF);
		send_item(FUNC_INSERT, '0);
		send_item(FUNC_INSERT, '1);
		send_item(FUNC_INSERT, 32'h7FFF_FFFF);
		send_item(FUNC_INSERT, 32'h8000_0000);
		send_item(FUNC_INSERT, 32'h7FFF_FFFF);
		send_item(FUNC_REMOVE, 32'h8000_0000);
		send_item(FUNC_REMOVE, '1);
		send_item(FUNC_REMOVE, 32'h5555_AAAA);
		send_item(FUNC_REMOVE, '0);
		send_item(FUNC_REMOVE, 32'hAAAA_5555);
		send_item(FUNC_REMOVE, '0);
	endtask

	// Fills the queue from empty, then tries inserts that must be refused.
	task automatic test_full_queue();
		for (int i = 0; i < CAPACITY; i++)
			send_item(FUNC_INSERT, $urandom_range(15) - 8);
		send_item(FUNC_INSERT, 32'h7FFF_FFFF);
		send_item(FUNC_INSERT, 32'h8000_0000);
		send_item(FUNC_REMOVE, '0);
		send_item(FUNC_INSERT, 32'h7FFF_FFFF);
		send_item(FUNC_INSERT, '0);
	endtask

	// Phases lean toward inserts or removes so the queue keeps swinging between
	// full and empty; one phase runs with no idle cycles at all.
	task automatic test_random_mix();
		int insert_pct[7] = '{85, 50, 15, 90, 30, 60, 10};
		for (int ph = 0; ph < 7; ph++) begin
			idle_pct = (ph == 3) ? 0 : 26;
			for (int i = 0; i < 200; i++) begin
				if ($urandom_range(99) < insert_pct[ph])
					send_item(FUNC_INSERT, pick_prio());
				else
					send_item(FUNC_REMOVE, $urandom);
			end
		end
		idle_pct = 26;
	endtask

	always @(posedge clk) begin
		queue_status_t exp_st;
		if (arst_n && done) begin
			if (status_q.size() == 0) begin
				$error("result strobe with no item outstanding");
				error_count++;
			end else begin
				exp_st = status_q.pop_front();
				if (done_ok !== exp_st.ok) begin
					$error("done_ok: expected %0b, actual %0b", exp_st.ok, done_ok);
					error_count++;
				end
				if (top_value !== exp_st.top) begin
					$error("top_value: expected %0d, actual %0d",
						$signed(exp_st.top), $signed(top_value));
					error_count++;
				end
				if (entry_count !== exp_st.count) begin
					$error("entry_count: expected %0d, actual %0d", exp_st.count, entry_count);
					error_count++;
				end
				if (is_empty !== exp_st.empty) begin
					$error("is_empty: expected %0b, actual %0b", exp_st.empty, is_empty);
					error_count++;
				end
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_empty_and_extremes();
		test_full_queue();
		test_random_mix();
		@(negedge clk);
		start = 1'b0;
		while (status_q.size() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
		if (status_q.size() != 0) begin
			$error("%0d results never arrived", status_q.size());
			error_count++;
		end
		if (error_count == 0)
			$display("PASS sorted_max_priority_queue");
		else
			$display("FAIL sorted_max_priority_queue");
		$finish;
	end

	initial begin
		#2ms;
		$display("FAIL sorted_max_priority_queue");
		$finish;
	end

endmodule
